/* rtl/ffha_pkg.sv */
// ---------------------------------------------------------------------------
// ffha_pkg: shared types and constants of the first-fit heap allocator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffha_pkg;

  localparam int unsigned HEAP_BYTES_DEF   = 262144;
  localparam int unsigned HEADER_BYTES_DEF = 12;
  localparam int unsigned MAX_BLOCKS_DEF   = 64;

  localparam int unsigned OFS_W  = 18;  // payload offset field width
  localparam int unsigned REQ_W  = 19;  // request size field width
  localparam int unsigned SIZE_W = 19;  // block size width (up to 256 KiB)

  // Operation codes
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  // One block table entry
  typedef struct packed {
    logic [OFS_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic              is_free;
  } blk_t;

endpackage

/* rtl/first_fit_heap_allocator.sv */
// ---------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit allocator with split and forward merge
// Each entry is read (S_RD) and then checked (S_CHK) in turn; a split or merge
// shifts the later entries one at a time, each read and then written back.
// One item at a time; busy is high from start until the strobe cycle.
// Reset: synchronous; after reset a clearing step writes entry 0 as one free
// block covering the heap before start is taken. Receiver cannot stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       func,
  input  logic [ffha_pkg::REQ_W-1:0] request_size,
  input  logic [ffha_pkg::OFS_W-1:0] release_offset,
  output logic                       done,
  output logic [ffha_pkg::OFS_W-1:0] payload_offset,
  output logic [1:0]                 status
);
  import ffha_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned RSZ_W = SIZE_W + 1;  // rounded request keeps its carry
  localparam logic [SIZE_W-1:0] HDR      = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] HDR_P8   = SIZE_W'(HEADER_BYTES + 8);
  localparam logic [SIZE_W-1:0] INIT_SZ  = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD, S_CHK, S_INS_RD, S_INS_WR, S_HEAD,
    S_NXT_RD, S_NXT_CHK, S_REM_RD, S_REM_WR, S_DONE
  } state_t;

  // Block table memory, one read port with registered data
  blk_t mem [MAX_BLOCKS];
  logic [IDX_W-1:0] rd_addr;
  blk_t             rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  blk_t             wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  k;       // scanned entry
  logic [CNT_W-1:0]  j;       // shift pointer
  logic              op;
  logic [RSZ_W-1:0]  sz;
  logic [OFS_W-1:0]  rel;
  blk_t              hit;     // entry found, updated copy
  blk_t              tail;    // entry to insert
  logic [SIZE_W-1:0] rem_next;

  // Combinational tests on the entry read
  logic              fits, split, match;
  logic [RSZ_W-1:0]  sz_next;
  assign sz_next = (RSZ_W'(request_size) + RSZ_W'(7)) & ~RSZ_W'(7);
  assign fits  = rd_data.is_free && (RSZ_W'(rd_data.size) >= sz);
  assign split = (RSZ_W'(rd_data.size) > sz + RSZ_W'(HDR_P8)) && (count < MAX_CNT);
  assign match = (SIZE_W'(rd_data.offset) + HDR) == SIZE_W'(rel);
  assign rem_next = rd_data.size - sz[SIZE_W-1:0] - HDR;

  // Memory access control
  always_comb begin
    rd_addr = k[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = k[IDX_W-1:0];
    wr_data = hit;
    case (state)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = '{offset: '0, size: INIT_SZ, is_free: 1'b1};
      end
      S_INS_RD: rd_addr = IDX_W'(j - CNT_W'(1));
      S_INS_WR: begin
        wr_en = 1'b1; wr_addr = j[IDX_W-1:0]; wr_data = rd_data;
      end
      S_HEAD: begin
        wr_en = 1'b1; wr_addr = k[IDX_W-1:0]; wr_data = hit;
      end
      S_NXT_RD: rd_addr = IDX_W'(k + CNT_W'(1));
      S_REM_RD: rd_addr = IDX_W'(j + CNT_W'(1));
      S_REM_WR: begin
        wr_en = 1'b1; wr_addr = j[IDX_W-1:0]; wr_data = rd_data;
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      count <= CNT_W'(1);
      done  <= 1'b0;
      k     <= '0;
      j     <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (start) begin
            op  <= func;
            sz  <= sz_next;
            rel <= release_offset;
            k   <= '0;
            j   <= '0;
            payload_offset <= '0;
            if (func == FUNC_RELEASE && release_offset == '0) begin
              status <= ST_OK;
              state  <= S_DONE;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (op == FUNC_ALLOC && fits) begin
            hit <= '{offset: rd_data.offset,
                     size: split ? sz[SIZE_W-1:0] : rd_data.size,
                     is_free: 1'b0};
            payload_offset <= rd_data.offset + OFS_W'(HEADER_BYTES);
            status <= ST_OK;
            if (split) begin
              tail.offset <= rd_data.offset + OFS_W'(HDR + sz[SIZE_W-1:0]);
              tail.size   <= rem_next;
              tail.is_free <= 1'b1;
              j     <= count;
              state <= (count == k + CNT_W'(1)) ? S_HEAD : S_INS_RD;
            end else begin
              state <= S_HEAD;
            end
          end else if (op == FUNC_RELEASE && match) begin
            hit <= '{offset: rd_data.offset, size: rd_data.size, is_free: 1'b1};
            status <= ST_OK;
            state  <= S_NXT_RD;
          end else if (k + CNT_W'(1) >= count) begin
            status <= (op == FUNC_ALLOC) ? ST_NO_FIT : ST_UNKNOWN;
            state  <= S_DONE;
          end else begin
            k     <= k + CNT_W'(1);
            state <= S_RD;
          end
        end
        // Shift entries k+1..count-1 up by one, from the top down
        S_INS_RD: state <= S_INS_WR;
        S_INS_WR: begin
          j     <= j - CNT_W'(1);
          state <= (j - CNT_W'(1) == k + CNT_W'(1)) ? S_HEAD : S_INS_RD;
        end
        // Write the found entry, and the tail entry after a split
        S_HEAD: begin
          if (op == FUNC_ALLOC && j != '0) begin
            hit   <= tail;
            k     <= k + CNT_W'(1);
            j     <= '0;
            count <= count + CNT_W'(1);
            state <= S_HEAD;
          end else begin
            state <= S_DONE;
          end
        end
        // Release: look at the successor for a merge
        S_NXT_RD: state <= (k + CNT_W'(1) < count) ? S_NXT_CHK : S_HEAD;
        S_NXT_CHK: begin
          if (rd_data.is_free) begin
            hit.size <= hit.size + HDR + rd_data.size;
            j        <= k + CNT_W'(1);
            state    <= (k + CNT_W'(2) < count) ? S_REM_RD : S_HEAD;
            count    <= count - CNT_W'(1);
          end else begin
            state <= S_HEAD;
          end
        end
        // Shift entries down by one over the removed successor
        S_REM_RD: state <= S_REM_WR;
        S_REM_WR: begin
          j     <= j + CNT_W'(1);
          state <= (j + CNT_W'(1) < count) ? S_REM_RD : S_HEAD;
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= MAX_CNT))
    else $error("block count out of range");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("strobe outside idle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");
  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    (done && payload_offset != '0) |-> status == ST_OK)
    else $error("grant with error status");

endmodule
